/* hw/rtl/mbss_pkg.sv */
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared types and constants of the masked byte signature scanner.
// ----------------------------------------------------------------------------
package mbss_pkg;

    localparam int LEN_W    = 5;
    localparam int PAT_W    = 64;
    localparam int KINDS_W  = 32;
    localparam int OFFS_W   = 32;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [1:0]           t_kind;

    localparam t_cfg_idx CFG_PATTERN_LENGTH = 2'd0;
    localparam t_cfg_idx CFG_PATTERN_LOW    = 2'd1;
    localparam t_cfg_idx CFG_PATTERN_HIGH   = 2'd2;
    localparam t_cfg_idx CFG_POSITION_KINDS = 2'd3;

    localparam t_kind KIND_EXACT   = 2'd0;
    localparam t_kind KIND_CAPTURE = 2'd2;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

endpackage

/* hw/rtl/mbss_front.sv */
// ----------------------------------------------------------------------------
// mbss_front
// Configuration registers, byte window, region counter and pattern check.
// Pushes one record per match that has capture positions.
// ----------------------------------------------------------------------------
module mbss_front #(
    parameter int MAX_PATTERN = 16,
    parameter int REC_W       = MAX_PATTERN * 9 + mbss_pkg::OFFS_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  mbss_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [mbss_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_region_last,
    input  logic                       i_q_full,
    output logic                       o_in_stall,
    output logic                       o_push,
    output logic [REC_W-1:0]           o_rec
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = mbss_pkg::LEN_W;
    localparam int OFFS_W = mbss_pkg::OFFS_W;

    logic [LEN_W-1:0]                 r_len;
    logic [mbss_pkg::PAT_W-1:0]       r_pat_lo;
    logic [mbss_pkg::PAT_W-1:0]       r_pat_hi;
    logic [mbss_pkg::KINDS_W-1:0]     r_kinds;
    logic [7:0]                       r_win [MAX_PATTERN];
    logic [OFFS_W-1:0]                r_seen;

    logic [7:0]                       w_new [MAX_PATTERN];
    logic [2*mbss_pkg::PAT_W-1:0]     pat;
    logic [LEN_W-1:0]                 eff_len;
    logic [LEN_W-1:0]                 idx;
    logic [OFFS_W-1:0]                n_seen;
    logic [MAX_PATTERN-1:0]           mism;
    logic [MAX_PATTERN-1:0]           cap;
    logic [MAX_PATTERN*8-1:0]         capb;
    logic [7:0]                       sel;
    logic                             accept;
    logic                             check;

    assign pat        = {r_pat_hi, r_pat_lo};
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = r_len;
        end
    end

    always_comb begin
        w_new[0] = i_data_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            w_new[i] = r_win[i-1];
        end
        idx = '0;
        sel = '0;
        for (int p = 0; p < MAX_PATTERN; p++) begin
            idx = eff_len - LEN_W'(p) - LEN_W'(1);
            sel = w_new[idx[IDX_W-1:0]];
            mism[p] = (LEN_W'(p) < eff_len)
                      && (r_kinds[2*p +: 2] == mbss_pkg::KIND_EXACT)
                      && (sel != pat[8*p +: 8]);
            cap[p]  = (LEN_W'(p) < eff_len)
                      && (r_kinds[2*p +: 2] == mbss_pkg::KIND_CAPTURE);
            capb[8*p +: 8] = sel;
        end
    end

    assign n_seen = (r_seen == {OFFS_W{1'b1}}) ? r_seen : r_seen + OFFS_W'(1);
    assign check  = n_seen >= OFFS_W'(eff_len);
    assign o_push = accept && check && (mism == '0) && (cap != '0);
    assign o_rec  = {n_seen - OFFS_W'(eff_len), cap, capb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_W'(1);
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_kinds  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mbss_pkg::CFG_PATTERN_LENGTH: r_len    <= i_cfg_data[LEN_W-1:0];
                mbss_pkg::CFG_PATTERN_LOW:    r_pat_lo <= i_cfg_data;
                mbss_pkg::CFG_PATTERN_HIGH:   r_pat_hi <= i_cfg_data;
                mbss_pkg::CFG_POSITION_KINDS: r_kinds  <= i_cfg_data[mbss_pkg::KINDS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept) begin
            r_seen <= i_region_last ? '0 : n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= w_new[i];
            end
        end
    end

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (accept && check && !i_q_full))
        else $error("record pushed without an accepted byte");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eff_len != '0) && (eff_len <= LEN_W'(MAX_PATTERN)))
        else $error("effective length out of range");

    a_seen_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_region_last) |=> (r_seen == '0))
        else $error("region counter not cleared at region end");

endmodule

/* hw/rtl/mbss_queue.sv */
// ----------------------------------------------------------------------------
// mbss_queue
// Small first-word-fall-through queue of match records.
// ----------------------------------------------------------------------------
module mbss_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 176
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output mbss_pkg::t_q_stat o_stat,
    output logic [WIDTH-1:0]  o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_data       = r_mem[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.valid)
        else $error("pop from empty queue");

endmodule

/* hw/rtl/mbss_back.sv */
// ----------------------------------------------------------------------------
// mbss_back
// Walks the capture mask of one match record and emits one captured byte per
// transfer through an output register.
// ----------------------------------------------------------------------------
module mbss_back #(
    parameter int MAX_PATTERN = 16,
    parameter int REC_W       = MAX_PATTERN * 9 + mbss_pkg::OFFS_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mbss_pkg::t_q_stat             i_q_stat,
    input  logic [REC_W-1:0]              i_rec,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [7:0]                    o_captured_byte,
    output logic [mbss_pkg::OFFS_W-1:0]   o_match_offset,
    output logic                          o_match_last
);

    localparam int OFFS_W = mbss_pkg::OFFS_W;

    logic                     r_busy;
    logic [MAX_PATTERN*8-1:0] r_bytes;
    logic [MAX_PATTERN-1:0]   r_mask;
    logic [OFFS_W-1:0]        r_offset;
    logic                     r_ov;
    logic [7:0]               r_byte;
    logic [OFFS_W-1:0]        r_ooffs;
    logic                     r_last;

    logic [MAX_PATTERN-1:0]   sel_oh;
    logic [MAX_PATTERN-1:0]   rest;
    logic [7:0]               sel_byte;
    logic                     emit;
    logic                     emit_last;

    assign sel_oh    = r_mask & (~r_mask + MAX_PATTERN'(1));
    assign rest      = r_mask & ~sel_oh;
    assign emit      = r_busy && (!r_ov || !i_out_stall);
    assign emit_last = emit && (rest == '0);
    assign o_pop     = i_q_stat.valid && (!r_busy || emit_last);

    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (sel_oh[i]) begin
                sel_byte = sel_byte | r_bytes[8*i +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (emit_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes  <= i_rec[MAX_PATTERN*8-1:0];
            r_mask   <= i_rec[MAX_PATTERN*9-1:MAX_PATTERN*8];
            r_offset <= i_rec[REC_W-1:MAX_PATTERN*9];
        end else if (emit) begin
            r_mask <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte  <= sel_byte;
            r_ooffs <= r_offset;
            r_last  <= (rest == '0);
        end
    end

    assign o_out_valid     = r_ov;
    assign o_captured_byte = r_byte;
    assign o_match_offset  = r_ooffs;
    assign o_match_last    = r_last;

    a_busy_has_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("active record with empty capture mask");

    a_emit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> $onehot(sel_oh))
        else $error("capture select not one-hot");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_last && !o_pop) |=> !r_busy)
        else $error("record not released after last capture");

endmodule

/* hw/rtl/masked_byte_signature_scanner_top.sv */
// Path: a matching byte's record goes through the match queue and the back end's
//   record registers; its captured bytes then leave through the output register.
// Throughput: one byte per cycle in while the match queue has room; one captured
//   byte per cycle out while i_out_stall is low, set by the single output register.
// Reset: synchronous, active low; clears config to defaults, region counter,
//   queue and output valid.
// ----------------------------------------------------------------------------
// masked_byte_signature_scanner_top
// Masked byte signature scanner: front check, match queue, capture emitter.
// ----------------------------------------------------------------------------
module masked_byte_signature_scanner_top #(
    parameter int MAX_PATTERN = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  mbss_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [mbss_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_region_last,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_captured_byte,
    output logic [mbss_pkg::OFFS_W-1:0]   o_match_offset,
    output logic                          o_match_last
);

    localparam int REC_W = MAX_PATTERN * 9 + mbss_pkg::OFFS_W;

    logic              push;
    logic              pop;
    logic [REC_W-1:0]  rec_in;
    logic [REC_W-1:0]  rec_out;
    mbss_pkg::t_q_stat q_stat;

    mbss_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .REC_W       (REC_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_region_last (i_region_last),
        .i_q_full      (q_stat.full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_rec         (rec_in)
    );

    mbss_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_data  (rec_out)
    );

    mbss_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .REC_W       (REC_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (q_stat),
        .i_rec           (rec_out),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_captured_byte (o_captured_byte),
        .o_match_offset  (o_match_offset),
        .o_match_last    (o_match_last)
    );

endmodule

/* tb/mbss_capture_checker.sv */
// ----------------------------------------------------------------------------
// mbss_capture_checker
// Watches the configuration port and both byte channels of the scanner. It
// keeps its own window, region counter and pattern registers, predicts the
// captured bytes each accepted input byte causes, and compares every output
// transfer field by field against the oldest predicted capture.
// ----------------------------------------------------------------------------
module mbss_capture_checker
    import mbss_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_region_last,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [7:0]         i_captured_byte,
    input  logic [OFFS_W-1:0]  i_match_offset,
    input  logic               i_match_last,
    output int                 o_pending,
    output int                 o_failures
);

    typedef struct packed {
        logic [7:0]        byte_val;
        logic [OFFS_W-1:0] offset;
        logic              last;
    } t_capture;

    t_capture           expected_captures[$];
    t_capture           oldest;
    logic [LEN_W-1:0]   cfg_len;
    logic [PAT_W-1:0]   cfg_low;
    logic [PAT_W-1:0]   cfg_high;
    logic [KINDS_W-1:0] cfg_kinds;
    logic [7:0]         window[MAX_PATTERN];
    logic [OFFS_W-1:0]  region_count;
    int                 mismatches = 0;

    assign o_failures = mismatches;

    function automatic t_kind kind_at(input int pos);
        return cfg_kinds[2*pos +: 2];
    endfunction

    task automatic scan_byte(input logic [7:0] data, input logic region_end);
        int                 n;
        int                 p;
        int                 total;
        int                 k;
        logic               hit;
        logic [2*PAT_W-1:0] pat;
        logic [OFFS_W-1:0]  start;
        t_capture           cap;
        n = (cfg_len == 0) ? 1 : (cfg_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg_len);
        pat = {cfg_high, cfg_low};
        for (p = MAX_PATTERN - 1; p > 0; p--) begin
            window[p] = window[p-1];
        end
        window[0] = data;
        if (region_count != '1) begin
            region_count++;
        end
        if (region_count >= n) begin
            hit = 1'b1;
            total = 0;
            for (p = 0; p < n; p++) begin
                if (kind_at(p) == KIND_EXACT && window[n-1-p] != pat[8*p +: 8]) begin
                    hit = 1'b0;
                end
                if (kind_at(p) == KIND_CAPTURE) begin
                    total++;
                end
            end
            if (hit) begin
                start = region_count - n;
                k = 0;
                for (p = 0; p < n; p++) begin
                    if (kind_at(p) == KIND_CAPTURE) begin
                        cap.byte_val = window[n-1-p];
                        cap.offset   = start;
                        cap.last     = (k == total - 1);
                        expected_captures = {expected_captures, cap};
                        k++;
                    end
                end
            end
        end
        if (region_end) begin
            window = '{default: '0};
            region_count = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_len      = LEN_W'(1);
            cfg_low      = '0;
            cfg_high     = '0;
            cfg_kinds    = '0;
            window       = '{default: '0};
            region_count = '0;
            expected_captures.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PATTERN_LENGTH: cfg_len   = i_cfg_data[LEN_W-1:0];
                    CFG_PATTERN_LOW:    cfg_low   = i_cfg_data;
                    CFG_PATTERN_HIGH:   cfg_high  = i_cfg_data;
                    CFG_POSITION_KINDS: cfg_kinds = i_cfg_data[KINDS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                scan_byte(i_data_byte, i_region_last);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_captures.size() == 0) begin
                    $error("unexpected transfer: captured_byte %02h, match_offset %0h",
                           i_captured_byte, i_match_offset);
                    mismatches++;
                end else begin
                    oldest = expected_captures.pop_front();
                    if (i_captured_byte !== oldest.byte_val) begin
                        $error("captured_byte: expected %02h, actual %02h",
                               oldest.byte_val, i_captured_byte);
                        mismatches++;
                    end
                    if (i_match_offset !== oldest.offset) begin
                        $error("match_offset: expected %0h, actual %0h",
                               oldest.offset, i_match_offset);
                        mismatches++;
                    end
                    if (i_match_last !== oldest.last) begin
                        $error("match_last: expected %0b, actual %0b",
                               oldest.last, i_match_last);
                        mismatches++;
                    end
                end
            end
        end
        o_pending <= expected_captures.size();
    end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the masked byte signature scanner through a short directed set of
// patterns and byte streams, then several randomly configured phases that
// mix well-formed pattern windows, corrupted windows and noise, with random
// bursts on the input side and random stalls on the output side. A separate
// checker predicts and compares; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import mbss_pkg::*;

    localparam int    MAX_PATTERN       = 16;
    localparam t_kind KIND_WILDCARD     = 2'd1;
    localparam t_kind KIND_WILDCARD_ALT = 2'd3;
    localparam int    SETTLE_CYCLES     = 20;
    localparam int    HOLD_CYCLES       = 80;
    localparam int    PHASE_BYTES       = 50;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    t_cfg_idx           cfg_idx     = CFG_PATTERN_LENGTH;
    logic [CFG_W-1:0]   cfg_data    = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte   = '0;
    logic               region_last = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [7:0]         captured_byte;
    logic [OFFS_W-1:0]  match_offset;
    logic               match_last;
    int                 pending;
    int                 failures;

    int                 hold_req   = 0;
    int                 burst_left = 0;
    int                 cur_n      = 1;
    logic [2*PAT_W-1:0] cur_pat    = '0;
    logic [KINDS_W-1:0] cur_kinds  = '0;

    masked_byte_signature_scanner_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (data_byte),
        .i_region_last   (region_last),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_captured_byte (captured_byte),
        .o_match_offset  (match_offset),
        .o_match_last    (match_last)
    );

    mbss_capture_checker #(.MAX_PATTERN(MAX_PATTERN)) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_data_byte     (data_byte),
        .i_region_last   (region_last),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_captured_byte (captured_byte),
        .i_match_offset  (match_offset),
        .i_match_last    (match_last),
        .o_pending       (pending),
        .o_failures      (failures)
    );

    initial begin : clock_gen
        forever #6 clk = ~clk;
    end

    initial begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Output side: random stall stretches, plus a long hold on request.
    initial begin : out_pacing
        int left;
        int mode;
        int hold_left;
        int holds_served;
        left = 0;
        mode = 0;
        hold_left = 0;
        holds_served = 0;
        forever begin
            @(posedge clk);
            if (hold_req != holds_served) begin
                holds_served = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(5, 40);
                end
                left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 2) == 0);
                    2:       out_stall <= ($urandom_range(0, 1) == 0);
                    default: out_stall <= left[1];
                endcase
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_pattern(input logic [LEN_W-1:0] len, input logic [PAT_W-1:0] lo,
                                input logic [PAT_W-1:0] hi, input logic [KINDS_W-1:0] kinds);
        write_reg(CFG_PATTERN_LENGTH, CFG_W'(len));
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_POSITION_KINDS, CFG_W'(kinds));
        cfg_we <= 1'b0;
        cur_n = (len == 0) ? 1 : (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
        cur_pat = {hi, lo};
        cur_kinds = kinds;
    endtask

    // Offer one byte; open a new burst after a random gap when the last one ends.
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        data_byte   <= b;
        region_last <= last;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int                 ph;
        int                 p;
        int                 i;
        int                 r;
        int                 k;
        int                 sent;
        int                 bp;
        logic               broken;
        logic [7:0]         b;
        logic [LEN_W-1:0]   len;
        logic [KINDS_W-1:0] kinds;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Length zero acts as one; every byte is captured, offsets restart per region.
        load_pattern(LEN_W'(0), '0, '0, {30'd0, KIND_CAPTURE});
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h5A, 1'b1);
        push_byte(8'hA5, 1'b0);
        wait_idle();

        // Oversized length clamps to the full window; all sixteen positions capture.
        load_pattern(LEN_W'(31), {$urandom, $urandom}, {$urandom, $urandom},
                     {16{KIND_CAPTURE}});
        for (i = 0; i < MAX_PATTERN; i++) begin
            push_byte(8'(i * 17), i == MAX_PATTERN - 1);
        end
        wait_idle();

        // Matches with no capture position, wildcard and kind three.
        load_pattern(LEN_W'(3), 64'hFF, '0,
                     {26'd0, KIND_WILDCARD_ALT, KIND_WILDCARD, KIND_EXACT});
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'h02, 1'b0);
        wait_idle();

        for (ph = 0; ph < 5; ph++) begin
            if (ph == 1) begin
                load_pattern(LEN_W'(2), {$urandom, $urandom}, {$urandom, $urandom},
                             {28'd0, KIND_CAPTURE, KIND_CAPTURE});
                hold_req++;
            end else begin
                case (ph)
                    0:       len = LEN_W'(1);
                    2:       len = LEN_W'(MAX_PATTERN);
                    3:       len = LEN_W'($urandom_range(0, 31));
                    default: len = LEN_W'($urandom_range(2, 8));
                endcase
                for (p = 0; p < MAX_PATTERN; p++) begin
                    r = $urandom_range(0, 9);
                    kinds[2*p +: 2] = (r < 3) ? KIND_EXACT : (r < 5) ? KIND_WILDCARD :
                                      (r < 9) ? KIND_CAPTURE : KIND_WILDCARD_ALT;
                end
                load_pattern(len, {$urandom, $urandom}, {$urandom, $urandom}, kinds);
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                r = $urandom_range(0, 9);
                if (r < 8) begin
                    broken = (r >= 6);
                    bp = $urandom_range(0, cur_n - 1);
                    for (p = 0; p < cur_n; p++) begin
                        b = (cur_kinds[2*p +: 2] == KIND_EXACT) ? cur_pat[8*p +: 8]
                                                                 : 8'($urandom);
                        if (broken && p == bp) begin
                            b ^= 8'(1 << $urandom_range(0, 7));
                        end
                        push_byte(b, $urandom_range(0, 24) == 0);
                        sent++;
                    end
                end else begin
                    k = $urandom_range(1, 4);
                    for (i = 0; i < k; i++) begin
                        push_byte(8'($urandom), $urandom_range(0, 24) == 0);
                        sent++;
                    end
                end
            end
            wait_idle();
        end

        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
